### rtl/bdq_pkg.sv
// shared types and codes for the bounded deque unit
package bdq_pkg;

  localparam int BDQ_DEPTH      = 16;
  localparam int BDQ_DATA_WIDTH = 32;

  // request codes
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_REAR  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_REAR   = 3'd3;
  localparam logic [2:0] REQ_LIST       = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_REAR,
    CELL_POP_FRONT,
    CELL_POP_REAR,
    CELL_ROTATE
  } cell_op_e;

  // controller state
  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } ctrl_state_e;

endpackage

### rtl/bounded_deque_unit.sv
// bounded deque built as a shifting chain of cells, front word in cell zero
// push and pop give a registered result word in the cycle after accept
// a list request gives one word per stored word, one per cycle unless the result side stalls, while input stalls
// throughput is one request per cycle while the result side does not stall and no list is in progress
// listing rotates the chain by one cell for each word it gives
// asynchronous active-low reset empties the deque; stored words are not cleared
module bounded_deque_unit
  import bdq_pkg::*;
#(
  parameter int DEPTH      = BDQ_DEPTH,
  parameter int DATA_WIDTH = BDQ_DATA_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   req_type_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] data_o,
  output logic [1:0]                   status_o,
  output logic                         last_o
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_valid;
  logic [DEPTH-1:0]      next_valid;
  logic [DEPTH-1:0]      is_rear;
  logic [DATA_WIDTH-1:0] rear_data;
  cell_op_e              cell_op;

  ctrl_state_e           state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         left_q, left_d;
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] out_data_q;
  logic [1:0]            out_status_q;
  logic                  out_last_q;

  logic                  accept;
  logic                  out_free;
  logic                  load;
  logic [DATA_WIDTH-1:0] ld_data;
  logic [1:0]            ld_status;
  logic                  ld_last;

  // chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic                  left_valid;
    logic [DATA_WIDTH-1:0] right_data;
    logic                  right_valid;
    if (i == 0) begin : g_first
      assign left_data  = value_i;
      assign left_valid = 1'b1;
    end else begin : g_inner_l
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_r
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end
    bdq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (cell_op),
      .push_word_i  (value_i),
      .left_data_i  (left_data),
      .left_valid_i (left_valid),
      .right_data_i (right_data),
      .right_valid_i(right_valid),
      .front_data_i (cell_data[0]),
      .data_o       (cell_data[i]),
      .valid_o      (cell_valid[i])
    );
  end

  // rear word: the one valid cell whose right neighbor is empty
  assign next_valid = {1'b0, cell_valid[DEPTH-1:1]};
  assign is_rear    = cell_valid & ~next_valid;

  always_comb begin
    rear_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_data = rear_data | (is_rear[i] ? cell_data[i] : '0);
    end
  end

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q == ST_LIST) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // request decode, cell control and next state
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    left_d    = left_q;
    cell_op   = CELL_HOLD;
    load      = 1'b0;
    ld_data   = '0;
    ld_status = STAT_OK;
    ld_last   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
              load = 1'b1;
              if (cnt_q == CW'(DEPTH)) begin
                ld_status = STAT_FULL;
              end else begin
                cell_op = (req_type_i == REQ_PUSH_FRONT) ? CELL_PUSH_FRONT : CELL_PUSH_REAR;
                cnt_d   = cnt_q + CW'(1);
              end
            end
            REQ_POP_FRONT, REQ_POP_REAR: begin
              load = 1'b1;
              if (cnt_q == '0) begin
                ld_status = STAT_EMPTY;
              end else begin
                if (req_type_i == REQ_POP_FRONT) begin
                  cell_op = CELL_POP_FRONT;
                  ld_data = cell_data[0];
                end else begin
                  cell_op = CELL_POP_REAR;
                  ld_data = rear_data;
                end
                cnt_d = cnt_q - CW'(1);
              end
            end
            REQ_LIST: begin
              load = 1'b1;
              if (cnt_q == '0) begin
                ld_status = STAT_EMPTY;
              end else begin
                cell_op = CELL_ROTATE;
                ld_data = cell_data[0];
                ld_last = (cnt_q == CW'(1));
                if (cnt_q != CW'(1)) begin
                  state_d = ST_LIST;
                  left_d  = cnt_q - CW'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LIST: begin
        if (out_free) begin
          load    = 1'b1;
          cell_op = CELL_ROTATE;
          ld_data = cell_data[0];
          ld_last = (left_q == CW'(1));
          left_d  = left_q - CW'(1);
          if (left_q == CW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q   <= ld_data;
      out_status_q <= ld_status;
      out_last_q   <= ld_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = out_data_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

`ifndef SYNTHESIS
  // occupancy count matches the valid cells of the chain
  a_cnt_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(cnt_q))
    else $error("occupancy count differs from valid cells");

  // valid cells form a contiguous run from the front
  a_cells_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_valid & ~cell_valid) == '0)
    else $error("gap in the cell chain");

  // while listing a result word is always on offer
  a_list_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST) |-> out_valid_q)
    else $error("listing without a result word");

  // remaining list count stays below occupancy while listing
  a_list_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST) |-> (left_q != '0 && left_q < cnt_q))
    else $error("list counter out of range");
`endif

endmodule

### rtl/bdq_cell.sv
// one storage cell of the deque chain
module bdq_cell
  import bdq_pkg::*;
#(
  parameter int DATA_WIDTH = BDQ_DATA_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_op_e              op_i,
  input  logic [DATA_WIDTH-1:0] push_word_i,
  input  logic [DATA_WIDTH-1:0] left_data_i,
  input  logic                  left_valid_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,
  input  logic                  right_valid_i,
  input  logic [DATA_WIDTH-1:0] front_data_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  valid_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  valid_q, valid_d;

  // next word and occupancy of this cell
  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    case (op_i)
      CELL_PUSH_FRONT: begin
        data_d  = left_data_i;
        valid_d = left_valid_i;
      end
      CELL_PUSH_REAR: begin
        if (left_valid_i && !valid_q) begin
          data_d  = push_word_i;
          valid_d = 1'b1;
        end
      end
      CELL_POP_FRONT: begin
        data_d  = right_data_i;
        valid_d = right_valid_i;
      end
      CELL_POP_REAR: begin
        if (valid_q && !right_valid_i) begin
          valid_d = 1'b0;
        end
      end
      CELL_ROTATE: begin
        if (right_valid_i) begin
          data_d = right_data_i;
        end else if (valid_q) begin
          data_d = front_data_i;
        end
      end
      default: begin
      end
    endcase
  end

  // occupancy bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // stored word
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

### verif/tb_bounded_deque_unit.sv
// self-checking testbench for the bounded deque unit
`timescale 1ns / 1ps

module tb_bounded_deque_unit;
  import bdq_pkg::*;

  localparam int W = BDQ_DATA_WIDTH;
  // request codes that the block ignores
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
  localparam int RANDOM_REQS = 420;

  typedef struct packed {
    logic signed [W-1:0] data;
    logic [1:0]          status;
    logic                last;
  } deque_word_t;

  // predicts the deque and checks every result word in order
  class deque_scoreboard;
    logic signed [W-1:0] ring [BDQ_DEPTH];
    int unsigned front_slot;
    int unsigned fill;
    deque_word_t pending_q[$];
    int errors;
    int checked;
    int full_hits;
    int empty_hits;
    int list_reqs;

    function new();
      front_slot = 0;
      fill       = 0;
      errors     = 0;
      checked    = 0;
      full_hits  = 0;
      empty_hits = 0;
      list_reqs  = 0;
    endfunction

    function int unsigned slot(int unsigned k);
      return (front_slot + k) % BDQ_DEPTH;
    endfunction

    function void add_word(logic signed [W-1:0] data, logic [1:0] status, logic last);
      deque_word_t w;
      w.data   = data;
      w.status = status;
      w.last   = last;
      pending_q.push_back(w);
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // update the deque for one accepted request and queue the words it gives
    function void note_request(logic [2:0] req, logic signed [W-1:0] val);
      logic signed [W-1:0] popped;
      int unsigned k;
      case (req)
        REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
          if (fill == BDQ_DEPTH) begin
            full_hits++;
            add_word('0, STAT_FULL, 1'b1);
          end else begin
            if (req == REQ_PUSH_FRONT) begin
              front_slot = (front_slot == 0) ? BDQ_DEPTH - 1 : front_slot - 1;
              ring[front_slot] = val;
            end else begin
              ring[slot(fill)] = val;
            end
            fill++;
            add_word('0, STAT_OK, 1'b1);
          end
        end
        REQ_POP_FRONT, REQ_POP_REAR: begin
          if (fill == 0) begin
            empty_hits++;
            add_word('0, STAT_EMPTY, 1'b1);
          end else begin
            if (req == REQ_POP_FRONT) begin
              popped     = ring[front_slot];
              front_slot = slot(1);
            end else begin
              popped = ring[slot(fill - 1)];
            end
            fill--;
            add_word(popped, STAT_OK, 1'b1);
          end
        end
        REQ_LIST: begin
          list_reqs++;
          if (fill == 0) begin
            empty_hits++;
            add_word('0, STAT_EMPTY, 1'b1);
          end else begin
            for (k = 0; k < fill; k++)
              add_word(ring[slot(k)], STAT_OK, k + 1 == fill);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // compare one accepted result word with the oldest prediction
    task check_result(logic signed [W-1:0] data, logic [1:0] status, logic last);
      deque_word_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("result word with nothing pending: data %0d status %0d last %0b",
                         data, status, last));
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (data !== want.data)
        report($sformatf("word %0d data %0d, predicted %0d", checked, data, want.data));
      if (status !== want.status)
        report($sformatf("word %0d status %0d, predicted %0d", checked, status, want.status));
      if (last !== want.last)
        report($sformatf("word %0d last %0b, predicted %0b", checked, last, want.last));
    endtask
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [2:0]          req_type_i  = REQ_PUSH_FRONT;
  logic signed [W-1:0] value_i     = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic signed [W-1:0] data_o;
  logic [1:0]          status_o;
  logic                last_o;

  deque_scoreboard sb;
  bit no_idle = 1'b0;
  int sent_reqs = 0;

  bounded_deque_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (data_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 8);
  endfunction

  // mostly random words, with the extremes mixed in
  function automatic logic signed [W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(W-1){1'b0}}};
      1:       return {1'b0, {(W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // present one request after a random gap and hold it until accepted
  task automatic send_req(logic [2:0] req, logic signed [W-1:0] val);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(req, val);
    if (req <= REQ_LIST) sent_reqs++;
  endtask

  // stop sending until every predicted word has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // result side: random stall before taking each word
  initial begin
    int hold;
    forever begin
      hold = draw_gap();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(data_o, status_o, last_o);
  end

  // main sequence
  initial begin
    int mode;
    int r;
    int i;
    logic [2:0] req;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty deque: every read is rejected, unused codes do nothing
    send_req(REQ_LIST, '0);
    send_req(REQ_POP_FRONT, '1);
    send_req(REQ_POP_REAR, '0);
    for (i = REQ_UNUSED_LO; i <= REQ_UNUSED_HI; i++)
      send_req(i[2:0], pick_value());
    // extremes in and out, popping the last word empties it
    send_req(REQ_PUSH_FRONT, {1'b0, {(W-1){1'b1}}});
    send_req(REQ_PUSH_REAR, {1'b1, {(W-1){1'b0}}});
    send_req(REQ_POP_REAR, '0);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_POP_FRONT, '0);
    // fill from both ends, then overfill and list the full deque
    for (i = 0; i < BDQ_DEPTH; i++)
      send_req((i % 2 == 0) ? REQ_PUSH_FRONT : REQ_PUSH_REAR, pick_value());
    send_req(REQ_PUSH_FRONT, pick_value());
    send_req(REQ_PUSH_REAR, pick_value());
    send_req(REQ_LIST, pick_value());
    drain_results();

    // random part in blocks that lean toward filling, draining or neither
    mode = 0;
    i = 0;
    while (i < RANDOM_REQS) begin
      if (i % 30 == 0) begin
        mode    = $urandom_range(0, 2);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (i == RANDOM_REQS / 2) drain_results();
      r = $urandom_range(0, 99);
      if (r < 3)
        req = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
      else if (r < 13)
        req = REQ_LIST;
      else if (r < ((mode == 0) ? 68 : (mode == 1) ? 38 : 56))
        req = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR;
      else
        req = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_REAR;
      send_req(req, pick_value());
      if (req <= REQ_LIST) i++;
    end

    in_valid_i <= 1'b0;
    no_idle = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("covered %0d requests, %0d of them lists; %0d result words checked",
             sent_reqs, sb.list_reqs, sb.checked);
    $display("rejections seen: %0d on a full deque, %0d on an empty one; %0d mismatches",
             sb.full_hits, sb.empty_hits, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### bounded_deque_unit.f
rtl/bdq_pkg.sv
rtl/bdq_cell.sv
rtl/bounded_deque_unit.sv
verif/tb_bounded_deque_unit.sv
